[rtl/ket_pkg.sv]
`default_nettype none

package ket_pkg;

    localparam int FIELD_BITS = 32;

    typedef enum logic
    {
        CMD_LOOKUP = 1'b0,
        CMD_UPDATE = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        STATUS_DONE     = 2'd0,
        STATUS_APPENDED = 2'd1,
        STATUS_FULL     = 2'd2
    } status_t;

    typedef struct packed
    {
        logic rd_en;
        logic key_we;
        logic pay_we;
    } mem_ctl_t;

endpackage

`default_nettype wire

[rtl/keyed_entry_table.sv]
// Channel | Dir | Fields (low bit first)
// s_*     | in  | tuser: command; tdata: search_key, entry_payload
// m_*     | out | tuser: hit, status; tdata: result_key, result_payload
//
// One request is taken at a time; s_tready is low from accept until the
// result transfer completes. A request with a nonzero key walks the used
// entries one per cycle through the key RAM read port and stops at the
// first matching entry or after the last used entry; a zero key goes
// straight to the result. Reset empties the table by clearing the fill count.
// A stalled m_tready holds the result and the block.
`default_nettype none

module keyed_entry_table #(
    parameter int ENTRIES      = 16,
    parameter int KEY_BITS     = 32,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // search_key, entry_payload
    input  wire logic        s_tuser,  // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [63:0] m_tdata,  // result_key, result_payload
    output logic      [2:0]  m_tuser   // hit, status
);

    localparam int IW = $clog2(ENTRIES);

    ket_pkg::mem_ctl_t       mem_ctl;
    logic [IW-1:0]           rd_addr;
    logic [IW-1:0]           wr_addr;
    logic [KEY_BITS-1:0]     key_wdata;
    logic [KEY_BITS-1:0]     key_rdata;
    logic [PAYLOAD_BITS-1:0] pay_wdata;
    logic [PAYLOAD_BITS-1:0] pay_rdata;
    logic                    out_hit;
    logic [31:0]             out_key;
    logic [31:0]             out_payload;
    ket_pkg::status_t        out_status;
    ket_pkg::cmd_t           in_cmd;

    assign in_cmd = ket_pkg::cmd_t'(s_tuser);

    ket_seq #(
        .ENTRIES      (ENTRIES),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (in_cmd),
        .in_key      (s_tdata[31:0]),
        .in_payload  (s_tdata[63:32]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_hit     (out_hit),
        .out_key     (out_key),
        .out_payload (out_payload),
        .out_status  (out_status),
        .mem_ctl     (mem_ctl),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr),
        .key_wdata   (key_wdata),
        .pay_wdata   (pay_wdata),
        .key_rdata   (key_rdata),
        .pay_rdata   (pay_rdata)
    );

    ket_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (mem_ctl.key_we),
        .waddr (wr_addr),
        .wdata (key_wdata),
        .re    (mem_ctl.rd_en),
        .raddr (rd_addr),
        .rdata (key_rdata)
    );

    ket_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (ENTRIES)
    ) u_pay_ram (
        .clk   (clk),
        .we    (mem_ctl.pay_we),
        .waddr (wr_addr),
        .wdata (pay_wdata),
        .re    (mem_ctl.rd_en),
        .raddr (rd_addr),
        .rdata (pay_rdata)
    );

    assign m_tdata = {out_payload, out_key};
    assign m_tuser = {out_status, out_hit};

endmodule

`default_nettype wire

[rtl/ket_ram.sv]
`default_nettype none

module ket_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/ket_seq.sv]
`default_nettype none

module ket_seq #(
    parameter int ENTRIES      = 16,
    parameter int KEY_BITS     = 32,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire ket_pkg::cmd_t                       in_cmd,
    input  wire logic [ket_pkg::FIELD_BITS-1:0]      in_key,
    input  wire logic [ket_pkg::FIELD_BITS-1:0]      in_payload,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     out_hit,
    output logic      [ket_pkg::FIELD_BITS-1:0]      out_key,
    output logic      [ket_pkg::FIELD_BITS-1:0]      out_payload,
    output ket_pkg::status_t                         out_status,
    output ket_pkg::mem_ctl_t                        mem_ctl,
    output logic      [$clog2(ENTRIES)-1:0]          rd_addr,
    output logic      [$clog2(ENTRIES)-1:0]          wr_addr,
    output logic      [KEY_BITS-1:0]                 key_wdata,
    output logic      [PAYLOAD_BITS-1:0]             pay_wdata,
    input  wire logic [KEY_BITS-1:0]                 key_rdata,
    input  wire logic [PAYLOAD_BITS-1:0]             pay_rdata
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_RESP
    } state_t;

    state_t                    state_reg;
    ket_pkg::cmd_t             cmd_reg;
    logic [KEY_BITS-1:0]       key_reg;
    logic [PAYLOAD_BITS-1:0]   pay_reg;
    logic [CW-1:0]             scan_idx_reg;
    logic [IW-1:0]             last_idx_reg;
    logic                      cmp_valid_reg;
    logic [CW-1:0]             fill_cnt_reg;
    logic                      hit_reg;
    logic [ket_pkg::FIELD_BITS-1:0] rkey_reg;
    logic [ket_pkg::FIELD_BITS-1:0] rpay_reg;
    ket_pkg::status_t          status_reg;

    logic [KEY_BITS-1:0]       in_key_trim;
    logic                      scanning;
    logic                      match;
    logic                      at_end;
    logic                      full;
    logic                      is_update;

    assign in_key_trim = KEY_BITS'(in_key);
    assign scanning  = (state_reg == S_SCAN);
    assign match     = scanning && cmp_valid_reg && (key_rdata == key_reg);
    assign at_end    = scanning && !match && (scan_idx_reg == fill_cnt_reg);
    assign full      = (fill_cnt_reg == CW'(ENTRIES));
    assign is_update = (cmd_reg == ket_pkg::CMD_UPDATE);

    always_comb
    begin
        mem_ctl.rd_en  = scanning && !match && !at_end;
        mem_ctl.key_we = at_end && is_update && !full;
        mem_ctl.pay_we = (at_end && is_update && !full) || (match && is_update);
    end

    assign rd_addr   = scan_idx_reg[IW-1:0];
    assign wr_addr   = match ? last_idx_reg : fill_cnt_reg[IW-1:0];
    assign key_wdata = key_reg;
    assign pay_wdata = pay_reg;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_RESP);
    assign out_hit     = hit_reg;
    assign out_key     = rkey_reg;
    assign out_payload = rpay_reg;
    assign out_status  = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_cnt_reg  <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg       <= in_cmd;
                        key_reg       <= in_key_trim;
                        pay_reg       <= PAYLOAD_BITS'(in_payload);
                        scan_idx_reg  <= '0;
                        cmp_valid_reg <= 1'b0;
                        hit_reg       <= 1'b0;
                        rkey_reg      <= '0;
                        rpay_reg      <= '0;
                        status_reg    <= ket_pkg::STATUS_DONE;
                        if (in_key_trim == '0)
                        begin
                            state_reg <= S_RESP;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (match)
                    begin
                        hit_reg <= 1'b1;
                        if (!is_update)
                        begin
                            rkey_reg <= ket_pkg::FIELD_BITS'(key_rdata);
                            rpay_reg <= ket_pkg::FIELD_BITS'(pay_rdata);
                        end
                        cmp_valid_reg <= 1'b0;
                        state_reg     <= S_RESP;
                    end
                    else if (at_end)
                    begin
                        if (is_update)
                        begin
                            if (full)
                            begin
                                status_reg <= ket_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                status_reg   <= ket_pkg::STATUS_APPENDED;
                                fill_cnt_reg <= fill_cnt_reg + CW'(1);
                            end
                        end
                        cmp_valid_reg <= 1'b0;
                        state_reg     <= S_RESP;
                    end
                    else
                    begin
                        // advance: entry at scan_idx is compared next cycle
                        last_idx_reg  <= scan_idx_reg[IW-1:0];
                        scan_idx_reg  <= scan_idx_reg + CW'(1);
                        cmp_valid_reg <= 1'b1;
                    end
                end
                S_RESP:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_cnt_reg <= CW'(ENTRIES))
        else $error("fill count beyond table size");

    a_append_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.key_we |-> (fill_cnt_reg < CW'(ENTRIES)))
        else $error("key written into a full table");

    a_append_counts: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.key_we |=> (fill_cnt_reg == $past(fill_cnt_reg) + CW'(1)))
        else $error("append did not grow fill count");

    a_read_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.rd_en |-> (scan_idx_reg < fill_cnt_reg))
        else $error("read past used entries");

    a_write_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_ctl.key_we || mem_ctl.pay_we) |-> !mem_ctl.rd_en && is_update)
        else $error("write outside update finish");

endmodule

`default_nettype wire
